FILE: src/hbtm_pkg.sv
`timescale 1ns / 1ps

package hbtm_pkg;

  typedef enum logic [1:0] {
    COND_UNKNOWN = 2'd0,
    COND_RUNNING = 2'd1,
    COND_FAILED  = 2'd2
  } cond_e;

  typedef enum logic {
    CMD_REPORT = 1'b0,
    CMD_CHECK  = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_UNKNOWN_TIMEOUT = 1'b0,
    REG_ERROR_TIMEOUT   = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_READ,
    SEQ_CALC,
    SEQ_WRITE
  } seq_e;

  typedef struct packed {
    cond_e       cond;
    logic [31:0] stamp;
  } entry_t;

  localparam int unsigned CfgW = 31;
  localparam logic [CfgW-1:0] UnknownTimeoutReset = 31'd180000;
  localparam logic [CfgW-1:0] ErrorTimeoutReset   = 31'd300000;
  localparam logic [7:0] FullOn = 8'hFF;
  localparam int unsigned MaxOut = 8;

endpackage

FILE: src/hbtm_if.sv
`timescale 1ns / 1ps

interface hbtm_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  reporter_id;
  logic [1:0]  reported_status;
  logic [31:0] now_ms;

  modport source(output valid, command, reporter_id, reported_status, now_ms, input ready);
  modport sink(input valid, command, reporter_id, reported_status, now_ms, output ready);
endinterface

interface hbtm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] slot;
  logic [1:0] state_code;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] white;
  logic       last_of_run;

  modport source(output valid, slot, state_code, red, green, blue, white, last_of_run,
                 input ready);
  modport sink(input valid, slot, state_code, red, green, blue, white, last_of_run,
               output ready);
endinterface

FILE: src/hbtm_table.sv
`timescale 1ns / 1ps

module hbtm_table #(
  parameter int unsigned Depth = 8,
  parameter int unsigned IdxW  = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  hbtm_pkg::entry_t  wdata_i,
  input  logic [IdxW-1:0]   raddr_i,
  output hbtm_pkg::entry_t  rdata_o
);

  hbtm_pkg::entry_t mem_q [Depth];
  hbtm_pkg::entry_t rd_q;
  logic [Depth-1:0] valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  // never-written slots read back as the reset entry (unknown, time zero)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule

FILE: src/device_heartbeat_timeout_monitor_top.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload                                              | Transfer
// in_if   | in  | command, reporter_id, reported_status, now_ms        | valid & ready
// out_if  | out | slot, state_code, red, green, blue, white, last_of_run | valid & ready
// cfg     | in  | cfg_idx_i, cfg_data_i                                | cfg_we_i
//
// A report is written to the table and ready stays high. A check closes the input
// for a sweep that can stall on the output: each slot goes through table read,
// elapsed-time subtract and limit compare/write-back, with one shared subtractor.
// Reset clears the sequencer and valid bits, sets default limits; no clearing pass.
// A result waits in the output register; the sweep stalls only when it needs that
// register while it is still full and the sink holds ready low.

module device_heartbeat_timeout_monitor_top #(
  parameter int unsigned NUM_DEVICES = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  hbtm_in_if.sink                   in_if,
  hbtm_out_if.source                out_if,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [hbtm_pkg::CfgW-1:0] cfg_data_i
);

  localparam int unsigned IdxW   = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int unsigned OutCnt = (NUM_DEVICES < hbtm_pkg::MaxOut) ? NUM_DEVICES
                                                                     : hbtm_pkg::MaxOut;

  hbtm_pkg::seq_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0] now_q, now_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [hbtm_pkg::CfgW-1:0] unknown_q, error_q;

  logic out_valid_q, out_valid_d;
  logic [2:0] slot_q, slot_d;
  hbtm_pkg::cond_e cond_q, cond_d;
  logic last_q, last_d;

  logic             tbl_we;
  logic [IdxW-1:0]  tbl_waddr;
  hbtm_pkg::entry_t tbl_wdata;
  hbtm_pkg::entry_t tbl_rdata;

  logic [7:0]       slot_full;
  logic             id_ok;
  hbtm_pkg::cond_e  rep_cond;
  hbtm_pkg::cond_e  new_cond;
  logic             emit;
  logic             out_free;
  logic             accept;

  hbtm_table #(
    .Depth(NUM_DEVICES),
    .IdxW (IdxW)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(idx_q),
    .rdata_o(tbl_rdata)
  );

  assign accept    = in_if.valid && in_if.ready;
  assign slot_full = 8'(NUM_DEVICES) - in_if.reporter_id;
  assign id_ok     = (in_if.reporter_id != 8'd0) && (in_if.reporter_id <= 8'(NUM_DEVICES));
  assign rep_cond  = (in_if.reported_status == 2'd3) ? hbtm_pkg::COND_FAILED
                                                      : hbtm_pkg::cond_e'(in_if.reported_status);
  assign emit      = 32'(idx_q) < OutCnt;
  assign out_free  = !out_valid_q || out_if.ready;

  always_comb begin
    if (elapsed_q < {1'b0, error_q} && elapsed_q > {1'b0, unknown_q}) begin
      new_cond = hbtm_pkg::COND_UNKNOWN;
    end else if (elapsed_q > {1'b0, error_q}) begin
      new_cond = hbtm_pkg::COND_FAILED;
    end else begin
      new_cond = tbl_rdata.cond;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    now_d       = now_q;
    elapsed_d   = elapsed_q;
    out_valid_d = out_valid_q && !out_if.ready;
    slot_d      = slot_q;
    cond_d      = cond_q;
    last_d      = last_q;
    tbl_we      = 1'b0;
    tbl_waddr   = idx_q;
    tbl_wdata   = '{cond: new_cond, stamp: tbl_rdata.stamp};

    unique case (state_q)
      hbtm_pkg::SEQ_IDLE: begin
        if (accept) begin
          if (in_if.command == hbtm_pkg::CMD_CHECK) begin
            idx_d   = '0;
            now_d   = in_if.now_ms;
            state_d = hbtm_pkg::SEQ_READ;
          end else if (id_ok) begin
            tbl_we    = 1'b1;
            tbl_waddr = slot_full[IdxW-1:0];
            tbl_wdata = '{cond: rep_cond, stamp: in_if.now_ms};
          end
        end
      end
      hbtm_pkg::SEQ_READ: begin
        state_d = hbtm_pkg::SEQ_CALC;
      end
      hbtm_pkg::SEQ_CALC: begin
        elapsed_d = now_q - tbl_rdata.stamp;
        state_d   = hbtm_pkg::SEQ_WRITE;
      end
      hbtm_pkg::SEQ_WRITE: begin
        if (!emit || out_free) begin
          tbl_we = 1'b1;
          if (emit) begin
            out_valid_d = 1'b1;
            slot_d      = 3'(idx_q);
            cond_d      = new_cond;
            last_d      = (idx_q == IdxW'(OutCnt - 1));
          end
          if (idx_q == IdxW'(NUM_DEVICES - 1)) begin
            state_d = hbtm_pkg::SEQ_IDLE;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = hbtm_pkg::SEQ_READ;
          end
        end
      end
      default: state_d = hbtm_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hbtm_pkg::SEQ_IDLE;
      out_valid_q <= 1'b0;
      unknown_q   <= hbtm_pkg::UnknownTimeoutReset;
      error_q     <= hbtm_pkg::ErrorTimeoutReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (hbtm_pkg::reg_e'(cfg_idx_i))
          hbtm_pkg::REG_UNKNOWN_TIMEOUT: unknown_q <= cfg_data_i;
          hbtm_pkg::REG_ERROR_TIMEOUT:   error_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    now_q     <= now_d;
    elapsed_q <= elapsed_d;
    slot_q    <= slot_d;
    cond_q    <= cond_d;
    last_q    <= last_d;
  end

  assign in_if.ready        = (state_q == hbtm_pkg::SEQ_IDLE);
  assign out_if.valid       = out_valid_q;
  assign out_if.slot        = slot_q;
  assign out_if.state_code  = cond_q;
  assign out_if.red         = (cond_q == hbtm_pkg::COND_FAILED)  ? hbtm_pkg::FullOn : 8'd0;
  assign out_if.green       = (cond_q == hbtm_pkg::COND_RUNNING) ? hbtm_pkg::FullOn : 8'd0;
  assign out_if.blue        = (cond_q == hbtm_pkg::COND_UNKNOWN) ? hbtm_pkg::FullOn : 8'd0;
  assign out_if.white       = 8'd0;
  assign out_if.last_of_run = last_q;

endmodule

FILE: src/hbtm_checker.sv
`timescale 1ns / 1ps

module hbtm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_command_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_state_code_i,
  input logic [7:0] out_red_i,
  input logic       out_last_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a check keeps the input closed while the sweep runs
  a_check_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == hbtm_pkg::CMD_CHECK) |=> !in_ready_i)
    else $error("input open right after a check transfer");

  // a result other than the last one can only be waiting while the sweep runs
  a_mid_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |-> !in_ready_i)
    else $error("input open in the middle of a run");

  a_red_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_state_code_i == hbtm_pkg::COND_FAILED) ==
                     (out_red_i == hbtm_pkg::FullOn)))
    else $error("red channel disagrees with state code");

endmodule

bind device_heartbeat_timeout_monitor_top hbtm_checker u_hbtm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .in_command_i    (in_if.command),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_state_code_i(out_if.state_code),
  .out_red_i       (out_if.red),
  .out_last_i      (out_if.last_of_run)
);

FILE: tb/sv/hbtm_color_checker.sv
`timescale 1ns / 1ps

module hbtm_color_checker
  import hbtm_pkg::*;
#(
  parameter int unsigned NUM_DEVICES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hbtm_in_if                in_if,
  hbtm_out_if               out_if,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       pending_o
);

  localparam int unsigned EmitCnt = (NUM_DEVICES < MaxOut) ? NUM_DEVICES : MaxOut;

  typedef struct packed {
    logic [2:0] slot;
    cond_e      state_code;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic       last_of_run;
  } color_t;

  cond_e           dev_cond  [NUM_DEVICES];
  logic [31:0]     dev_stamp [NUM_DEVICES];
  logic [CfgW-1:0] unknown_limit;
  logic [CfgW-1:0] error_limit;
  color_t          expected_colors [$];
  color_t          head;

  function automatic void apply_report(logic [7:0] id, logic [1:0] status, logic [31:0] now);
    int unsigned idx;
    if (id >= 1 && id <= NUM_DEVICES) begin
      idx = NUM_DEVICES - id;
      // anything above failed saturates
      dev_cond[idx]  = (status > COND_FAILED) ? COND_FAILED : cond_e'(status);
      dev_stamp[idx] = now;
    end
  endfunction

  function automatic void sweep_and_emit(logic [31:0] now);
    logic [31:0] elapsed;
    color_t      c;
    for (int j = 0; j < NUM_DEVICES; j++) begin
      elapsed = now - dev_stamp[j];
      if (elapsed < {1'b0, error_limit} && elapsed > {1'b0, unknown_limit}) begin
        dev_cond[j] = COND_UNKNOWN;
      end else if (elapsed > {1'b0, error_limit}) begin
        dev_cond[j] = COND_FAILED;
      end
    end
    for (int k = 0; k < EmitCnt; k++) begin
      c.slot        = 3'(k);
      c.state_code  = dev_cond[k];
      c.red         = (dev_cond[k] == COND_FAILED)  ? FullOn : 8'd0;
      c.green       = (dev_cond[k] == COND_RUNNING) ? FullOn : 8'd0;
      c.blue        = (dev_cond[k] == COND_UNKNOWN) ? FullOn : 8'd0;
      c.white       = 8'd0;
      c.last_of_run = (k == EmitCnt - 1);
      expected_colors.push_back(c);
    end
  endfunction

  function automatic int unsigned field_mismatch(string name, logic [31:0] exp_v,
                                                 logic [31:0] act_v);
    if (exp_v === act_v) return 0;
    $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unknown_limit = UnknownTimeoutReset;
      error_limit   = ErrorTimeoutReset;
      for (int j = 0; j < NUM_DEVICES; j++) begin
        dev_cond[j]  = COND_UNKNOWN;
        dev_stamp[j] = '0;
      end
      expected_colors.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_UNKNOWN_TIMEOUT) unknown_limit = cfg_data_i;
        else error_limit = cfg_data_i;
      end
      // compare before predicting: a result can't belong to a check taken at this edge
      if (out_if.valid && out_if.ready) begin
        if (expected_colors.size() == 0) begin
          $error("unexpected result transfer for slot %0d", out_if.slot);
          mismatch_cnt_o++;
        end else begin
          head = expected_colors.pop_front();
          mismatch_cnt_o += field_mismatch("slot", 32'(head.slot), 32'(out_if.slot));
          mismatch_cnt_o += field_mismatch("state_code", 32'(head.state_code),
                                           32'(out_if.state_code));
          mismatch_cnt_o += field_mismatch("red", 32'(head.red), 32'(out_if.red));
          mismatch_cnt_o += field_mismatch("green", 32'(head.green), 32'(out_if.green));
          mismatch_cnt_o += field_mismatch("blue", 32'(head.blue), 32'(out_if.blue));
          mismatch_cnt_o += field_mismatch("white", 32'(head.white), 32'(out_if.white));
          mismatch_cnt_o += field_mismatch("last_of_run", 32'(head.last_of_run),
                                           32'(out_if.last_of_run));
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (in_if.command == CMD_CHECK) sweep_and_emit(in_if.now_ms);
        else apply_report(in_if.reporter_id, in_if.reported_status, in_if.now_ms);
      end
      pending_o = expected_colors.size();
    end
  end

endmodule

FILE: tb/sv/device_heartbeat_timeout_monitor_top_test.sv
`timescale 1ns / 1ps

module device_heartbeat_timeout_monitor_top_test;
  import hbtm_pkg::*;

  localparam int unsigned NumDev       = 8;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned SettleCycles = 30;
  localparam int unsigned PhaseItems   = 13;
  localparam logic [1:0]  StatusOver   = 2'd3;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic            cfg_idx;
  logic [CfgW-1:0] cfg_data;

  hbtm_in_if  in_ch ();
  hbtm_out_if out_ch ();

  int unsigned     tx_idle_pct = 0;
  int unsigned     rx_idle_pct = 0;
  int unsigned     hold_req = 0;
  int unsigned     mismatch_cnt;
  int unsigned     pending;
  logic [31:0]     clock_ms;
  logic [CfgW-1:0] unk_lim;
  logic [CfgW-1:0] err_lim;

  device_heartbeat_timeout_monitor_top #(.NUM_DEVICES(NumDev)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  hbtm_color_checker #(.NUM_DEVICES(NumDev)) color_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_if          (in_ch),
    .out_if         (out_ch),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls plus an occasional long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_request(cmd_e cmd, logic [7:0] id, logic [1:0] status,
                              logic [31:0] now);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.command         <= cmd;
    in_ch.reporter_id     <= id;
    in_ch.reported_status <= status;
    in_ch.now_ms          <= now;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // stop offering, let every expected result arrive, then let the sweep settle
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_limit(reg_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_UNKNOWN_TIMEOUT) unk_lim = val;
    else err_lim = val;
  endtask

  task automatic set_limits(logic [CfgW-1:0] unk, logic [CfgW-1:0] err);
    write_limit(REG_UNKNOWN_TIMEOUT, unk);
    write_limit(REG_ERROR_TIMEOUT, err);
  endtask

  // time steps cluster around both limits so elapsed values land on and next to them
  task automatic send_random(output bit counted);
    logic [31:0] step;
    int unsigned pick;
    case ($urandom_range(4))
      0: step = $urandom_range(50);
      1: step = {1'b0, unk_lim} + $urandom_range(2) - 1;
      2: step = {1'b0, err_lim} + $urandom_range(2) - 1;
      3: step = $urandom;
      default: step = $urandom_range({1'b0, err_lim});
    endcase
    clock_ms += step;
    pick = $urandom_range(9);
    counted = 1'b1;
    if (pick < 4) begin
      send_request(CMD_CHECK, 8'($urandom), 2'($urandom), clock_ms);
    end else if (pick < 8) begin
      send_request(CMD_REPORT, 8'($urandom_range(1, NumDev)), 2'($urandom_range(3)),
                   clock_ms);
    end else begin
      counted = 1'b0;
      send_request(CMD_REPORT, $urandom_range(1) ? 8'd0 : 8'($urandom_range(NumDev + 1, 255)),
                   2'($urandom_range(3)), clock_ms);
    end
  endtask

  initial begin : stimulus
    int unsigned n;
    bit          counted;
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = REG_UNKNOWN_TIMEOUT;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.command         = CMD_REPORT;
    in_ch.reporter_id     = '0;
    in_ch.reported_status = '0;
    in_ch.now_ms          = '0;
    unk_lim               = UnknownTimeoutReset;
    err_lim               = ErrorTimeoutReset;
    tx_idle_pct           = 30;
    rx_idle_pct           = 51;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset limits
    send_request(CMD_CHECK, 8'd0, COND_UNKNOWN, 32'd0);
    for (int d = 1; d <= NumDev; d++) send_request(CMD_REPORT, 8'(d), 2'(d), 32'd1000);
    // ids outside the table are ignored
    send_request(CMD_REPORT, 8'd0, COND_RUNNING, 32'd1000);
    send_request(CMD_REPORT, 8'(NumDev + 1), COND_RUNNING, 32'd1000);
    send_request(CMD_REPORT, 8'hFF, StatusOver, 32'd1000);
    // on the unknown limit, then just past it
    send_request(CMD_CHECK, 8'd0, COND_UNKNOWN, 32'd1000 + UnknownTimeoutReset);
    send_request(CMD_CHECK, 8'd0, COND_UNKNOWN, 32'd1001 + UnknownTimeoutReset);
    // on the error limit, then just past it
    send_request(CMD_CHECK, 8'd0, COND_UNKNOWN, 32'd1000 + ErrorTimeoutReset);
    send_request(CMD_CHECK, 8'd0, COND_UNKNOWN, 32'd1001 + ErrorTimeoutReset);
    // elapsed time across the 2^32 wrap
    send_request(CMD_REPORT, 8'd1, COND_RUNNING, 32'hFFFF_FF00);
    send_request(CMD_CHECK, 8'd0, COND_UNKNOWN, 32'h0000_0100);
    send_request(CMD_CHECK, 8'hFF, StatusOver, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_FFFF;

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          set_limits(31'd1000, 31'd3000);
        end
        1: begin
          set_limits(31'd0, 31'h7FFF_FFFF);
        end
        2: begin
          tx_idle_pct = 51;
          rx_idle_pct = 30;
          set_limits(31'h7FFF_FFFF, 31'd0);
        end
        3: begin
          set_limits(31'd5000, 31'd5000);
        end
        4: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          set_limits(UnknownTimeoutReset, ErrorTimeoutReset);
          // long result hold-off while checks keep coming: the input must back up
          hold_req++;
          repeat (6) begin
            clock_ms += $urandom_range(400000);
            send_request(CMD_CHECK, 8'($urandom), 2'($urandom), clock_ms);
          end
        end
        default: begin
          set_limits(31'($urandom_range(20000)), 31'($urandom_range(20000)));
        end
      endcase
      n = 0;
      while (n < PhaseItems) begin
        send_random(counted);
        if (counted) n++;
      end
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
